>>> hdl/hourly_sample_ring_history_core_assert.svh
// Assertion macros shared by the hourly sample history modules.
`ifndef HOURLY_SAMPLE_RING_HISTORY_CORE_ASSERT_SVH
`define HOURLY_SAMPLE_RING_HISTORY_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HSRH_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hsrh assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HSRH_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hsrh assertion failed");

`endif

>>> hdl/hsrh_pkg.sv
// Shared types and constants for the hourly sample history core.
package hsrh_pkg;

    // Ring depth; a power of two no larger than the read index range.
    localparam int unsigned DEPTH    = 64;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned BUCKET_W = 21;

    // Entry layout: temperature, humidity, sine, cosine.
    localparam int unsigned ENTRY_W  = 62;

    // epoch / 3600 == (epoch >> 4) / 225, done as a reciprocal multiply.
    localparam int unsigned EPOCH_W     = 32;
    localparam int unsigned HOUR_SHIFT  = 4;
    localparam int unsigned DIV_IN_W    = EPOCH_W - HOUR_SHIFT;
    localparam int unsigned RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP = 29'd305419897;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam int unsigned PROD_W      = DIV_IN_W + RECIP_W;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                command;
        logic [31:0]         epoch_seconds;
        logic signed [15:0]  temperature;
        logic [13:0]         humidity;
        logic signed [15:0]  hour_sine;
        logic signed [15:0]  hour_cosine;
        logic [IDX_W-1:0]    read_index;
    } t_in_beat;

    typedef struct packed {
        logic                recorded;
        logic [CNT_W-1:0]    stored_count;
        logic                is_full;
        logic                index_valid;
        logic signed [15:0]  out_temperature;
        logic [13:0]         out_humidity;
        logic signed [15:0]  out_hour_sine;
        logic signed [15:0]  out_hour_cosine;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC,
        S_FIN
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic mul;
        logic exec;
        logic out_load;
    } t_dp_cmd;

endpackage

>>> hdl/hourly_sample_ring_history_core.sv
// Top level of the hourly sample history core.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per item:
// a tick (command 0) with epoch seconds and readings, or a read (command 1)
// of a chronological index, 0 being the oldest entry.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one beat per
// item: recorded flag, entry count, full flag and, for reads, the entry.
// A tick stores an entry when nothing is recorded yet or its hour bucket
// (epoch / 3600) differs from the last record; epoch 0 stores nothing.
// Once the ring is full the oldest entry is overwritten.
// The controller walks each item through divide, store access and result load
// (one store port, one item), so the next input beat is taken only once the
// previous item has left the final step.
// A finished result waits in the output register; the next input beat is taken
// meanwhile and held in the final step until the receiver frees that register.
// Reset (synchronous, active low) empties the ring and drops any pending beat;
// store contents are not cleared, the count keeps unwritten slots out of view.
module hourly_sample_ring_history_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hsrh_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hsrh_pkg::t_out_beat o_out_data
);

    hsrh_pkg::t_dp_cmd w_cmd;

    hsrh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    hsrh_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

>>> hdl/hsrh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsrh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/hsrh_datapath.sv
// Datapath: input hold, hour bucket divider, ring pointers, store, result register.
module hsrh_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsrh_pkg::t_dp_cmd  i_cmd,
    input  hsrh_pkg::t_in_beat i_in_data,
    output hsrh_pkg::t_out_beat o_out_data
);

    hsrh_pkg::t_in_beat              r_in;
    logic [hsrh_pkg::BUCKET_W-1:0]   r_bucket;
    logic [hsrh_pkg::BUCKET_W-1:0]   r_last_bucket;
    logic                            r_has_recorded;
    logic [hsrh_pkg::ADDR_W-1:0]     r_oldest;
    logic [hsrh_pkg::CNT_W-1:0]      r_total;
    logic                            r_recorded;
    logic                            r_idx_valid;
    logic                            r_is_read;
    hsrh_pkg::t_out_beat             r_out;

    logic [hsrh_pkg::PROD_W-1:0]     w_prod;
    logic                            w_is_tick;
    logic                            w_record;
    logic                            w_full;
    logic [hsrh_pkg::ADDR_W-1:0]     w_waddr;
    logic [hsrh_pkg::ADDR_W-1:0]     w_raddr;
    logic [hsrh_pkg::ENTRY_W-1:0]    w_wdata;
    logic [hsrh_pkg::ENTRY_W-1:0]    w_rdata;
    logic                            w_we;
    logic                            w_re;

    // (epoch >> 4) * ceil(2^36 / 225) >> 36 is exact over 28-bit inputs.
    assign w_prod = hsrh_pkg::PROD_W'(r_in.epoch_seconds[hsrh_pkg::EPOCH_W-1:hsrh_pkg::HOUR_SHIFT])
                  * hsrh_pkg::PROD_W'(hsrh_pkg::RECIP);

    assign w_is_tick = (r_in.command == hsrh_pkg::CMD_TICK);
    assign w_record  = w_is_tick && (r_in.epoch_seconds != '0)
                    && (!r_has_recorded || (r_bucket != r_last_bucket));
    assign w_full    = (r_total == hsrh_pkg::CNT_W'(hsrh_pkg::DEPTH));

    // When full the low bits of the count are zero, so the slot is the oldest.
    assign w_waddr = r_oldest + r_total[hsrh_pkg::ADDR_W-1:0];
    assign w_raddr = r_oldest + r_in.read_index[hsrh_pkg::ADDR_W-1:0];
    assign w_wdata = {r_in.hour_cosine, r_in.hour_sine, r_in.humidity, r_in.temperature};
    assign w_we    = i_cmd.exec && w_record;
    assign w_re    = i_cmd.exec && !w_is_tick;

    hsrh_ram #(
        .WIDTH (hsrh_pkg::ENTRY_W),
        .DEPTH (hsrh_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.mul) begin
            r_bucket <= w_prod[hsrh_pkg::RECIP_SHIFT +: hsrh_pkg::BUCKET_W];
        end
        if (i_cmd.exec) begin
            r_recorded  <= w_record;
            r_is_read   <= !w_is_tick;
            r_idx_valid <= !w_is_tick
                        && (hsrh_pkg::CNT_W'(r_in.read_index) < r_total);
        end
        if (i_cmd.out_load) begin
            r_out.recorded     <= r_recorded;
            r_out.stored_count <= r_total;
            r_out.is_full      <= w_full;
            r_out.index_valid  <= r_idx_valid;
            if (r_is_read) begin
                r_out.out_temperature <= $signed(w_rdata[15:0]);
                r_out.out_humidity    <= w_rdata[29:16];
                r_out.out_hour_sine   <= $signed(w_rdata[45:30]);
                r_out.out_hour_cosine <= $signed(w_rdata[61:46]);
            end else begin
                r_out.out_temperature <= '0;
                r_out.out_humidity    <= '0;
                r_out.out_hour_sine   <= '0;
                r_out.out_hour_cosine <= '0;
            end
        end
    end

    // Ring bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest       <= '0;
            r_total        <= '0;
            r_last_bucket  <= '0;
            r_has_recorded <= 1'b0;
        end else if (w_we) begin
            if (w_full) begin
                r_oldest <= hsrh_pkg::ADDR_W'(r_oldest + 1'b1);
            end else begin
                r_total <= hsrh_pkg::CNT_W'(r_total + 1'b1);
            end
            r_last_bucket  <= r_bucket;
            r_has_recorded <= 1'b1;
        end
    end

    assign o_out_data = r_out;

`include "hourly_sample_ring_history_core_assert.svh"

    `HSRH_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1,
        r_total <= hsrh_pkg::CNT_W'(hsrh_pkg::DEPTH))
    `HSRH_ASSERT_NOW(a_oldest_only_when_full, i_clk, i_rst_n, r_oldest != '0, w_full)
    `HSRH_ASSERT_NEXT(a_write_marks_recorded, i_clk, i_rst_n, w_we,
        r_has_recorded && (r_total != '0))

endmodule

>>> hdl/hsrh_ctrl.sv
// Controller: sequences one item through divide, store access and result load.
module hsrh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hsrh_pkg::t_dp_cmd o_cmd
);

    hsrh_pkg::t_state r_state;
    hsrh_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hsrh_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            hsrh_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = hsrh_pkg::S_DIV;
                end
            end
            hsrh_pkg::S_DIV: begin
                o_cmd.mul = 1'b1;
                n_state   = hsrh_pkg::S_EXEC;
            end
            hsrh_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = hsrh_pkg::S_FIN;
            end
            hsrh_pkg::S_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = hsrh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hsrh_pkg::S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    assign o_out_valid = r_out_valid;

`include "hourly_sample_ring_history_core_assert.svh"

    `HSRH_ASSERT_NOW(a_load_into_free_slot, i_clk, i_rst_n, o_cmd.out_load, w_out_free)
    `HSRH_ASSERT_NEXT(a_one_item_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready)
    `HSRH_ASSERT_NEXT(a_fin_waits_on_stall, i_clk, i_rst_n,
        (r_state == hsrh_pkg::S_FIN) && !w_out_free, r_state == hsrh_pkg::S_FIN)

endmodule
